// File: rtl/mrhp_pkg.sv
// Shared types and constants for the MQTT response header parser.
package mrhp_pkg;

    // Longest base-128 remaining length encoding accepted, in bytes (1 to 4).
    localparam int unsigned MAX_LENGTH_BYTES = 4;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SEC_W   = 3;
    localparam int unsigned TYPE_W  = 4;
    localparam int unsigned QOS_W   = 2;
    localparam int unsigned LEN_W   = 28;
    localparam int unsigned TOPIC_W = 16;
    localparam int unsigned ID_W    = 16;

    // Section tags reported with every byte.
    localparam logic [SEC_W-1:0] SEC_FIRST  = 3'd0;
    localparam logic [SEC_W-1:0] SEC_LEN    = 3'd1;
    localparam logic [SEC_W-1:0] SEC_TOPLEN = 3'd2;
    localparam logic [SEC_W-1:0] SEC_TOPIC  = 3'd3;
    localparam logic [SEC_W-1:0] SEC_ID     = 3'd4;
    localparam logic [SEC_W-1:0] SEC_BODY   = 3'd5;

    // Control packet types that carry extra header fields.
    localparam logic [TYPE_W-1:0] TYPE_PUBLISH = 4'd3;
    localparam logic [TYPE_W-1:0] TYPE_PUBACK  = 4'd4;
    localparam logic [TYPE_W-1:0] TYPE_SUBACK  = 4'd9;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic [BYTE_W-1:0]  byte_out;
        logic [SEC_W-1:0]   section;
        logic [TYPE_W-1:0]  packet_type;
        logic [QOS_W-1:0]   qos;
        logic [LEN_W-1:0]   remaining_length;
        logic [TOPIC_W-1:0] topic_size;
        logic [ID_W-1:0]    packet_id;
        logic [LEN_W-1:0]   payload_length;
        logic               header_done;
        logic               packet_end;
        logic               error;
    } result_t;

endpackage

// File: rtl/mrhp_in_reg.sv
// Input register: holds one accepted byte until the parser consumes it.
module mrhp_in_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mrhp_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                           advance,
    output logic                           in_valid,
    output logic [mrhp_pkg::BYTE_W-1:0]    in_byte
);

    logic                        valid_reg;
    logic [mrhp_pkg::BYTE_W-1:0] byte_reg;

    // The register may be refilled when empty or when its byte moves on this cycle.
    assign s_ready  = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload is captured on each input transfer and needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
        end
    end

endmodule

// File: rtl/mrhp_parser.sv
// Header state and the per-byte decode; the state moves on when a byte advances.
module mrhp_parser #(
    parameter int unsigned MAX_LENGTH_BYTES = mrhp_pkg::MAX_LENGTH_BYTES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [mrhp_pkg::BYTE_W-1:0] in_byte,
    output mrhp_pkg::result_t           res
);

    typedef enum logic [mrhp_pkg::SEC_W-1:0] {
        PH_FIRST  = mrhp_pkg::SEC_FIRST,
        PH_LEN    = mrhp_pkg::SEC_LEN,
        PH_TOPLEN = mrhp_pkg::SEC_TOPLEN,
        PH_TOPIC  = mrhp_pkg::SEC_TOPIC,
        PH_ID     = mrhp_pkg::SEC_ID,
        PH_BODY   = mrhp_pkg::SEC_BODY
    } phase_t;

    phase_t                         phase_reg, phase_next, after_topic;
    logic [mrhp_pkg::TYPE_W-1:0]    type_reg, type_next;
    logic [mrhp_pkg::QOS_W-1:0]     qos_reg, qos_next;
    logic [mrhp_pkg::LEN_W-1:0]     acc_reg, acc_next;
    logic [2:0]                     lbc_reg, lbc_next;
    logic [mrhp_pkg::LEN_W-1:0]     left_reg, left_next;
    logic [mrhp_pkg::TOPIC_W-1:0]   tlen_reg, tlen_next;
    logic [mrhp_pkg::TOPIC_W-1:0]   tleft_reg, tleft_next;
    logic [mrhp_pkg::ID_W-1:0]      id_reg, id_next;
    logic [1:0]                     idc_reg, idc_next;

    logic [mrhp_pkg::LEN_W-1:0]     len_add;
    logic [17:0]                    need;
    logic [mrhp_pkg::LEN_W-1:0]     payload;
    logic                           hdone, pend, err, count_down, tl_known;

    // Seven payload bits of a length byte, placed at the weight of its position.
    always_comb begin
        case (lbc_reg[1:0])
            2'd0:    len_add = {21'd0, in_byte[6:0]};
            2'd1:    len_add = {14'd0, in_byte[6:0], 7'd0};
            2'd2:    len_add = {7'd0, in_byte[6:0], 14'd0};
            default: len_add = {in_byte[6:0], 21'd0};
        endcase
    end

    assign after_topic = (qos_reg != '0) ? PH_ID : PH_BODY;

    // Next state and flags for the byte in the input register.
    always_comb begin
        type_next  = type_reg;
        qos_next   = qos_reg;
        acc_next   = acc_reg;
        lbc_next   = lbc_reg;
        left_next  = left_reg;
        tlen_next  = tlen_reg;
        tleft_next = tleft_reg;
        id_next    = id_reg;
        idc_next   = idc_reg;
        phase_next = phase_reg;
        hdone      = 1'b0;
        pend       = 1'b0;
        err        = 1'b0;
        count_down = 1'b0;

        case (phase_reg)
            PH_LEN: begin
                if (lbc_reg < 3'd4) begin
                    acc_next = acc_reg + len_add;
                end
                lbc_next = lbc_reg + 3'd1;
                if (in_byte[7]) begin
                    // Continuation past the longest allowed encoding ends the packet.
                    if (lbc_next >= 3'(MAX_LENGTH_BYTES)) begin
                        err        = 1'b1;
                        pend       = 1'b1;
                        phase_next = PH_FIRST;
                    end
                end else begin
                    left_next = acc_next;
                    if (type_reg == mrhp_pkg::TYPE_PUBLISH) begin
                        phase_next = PH_TOPLEN;
                        lbc_next   = 3'd0;
                    end else if (type_reg == mrhp_pkg::TYPE_PUBACK ||
                                 type_reg == mrhp_pkg::TYPE_SUBACK) begin
                        phase_next = PH_ID;
                    end else begin
                        phase_next = PH_BODY;
                        hdone      = 1'b1;
                    end
                    // A zero length is short for types that expect header fields.
                    if (acc_next == '0) begin
                        pend       = 1'b1;
                        err        = (phase_next != PH_BODY);
                        phase_next = PH_FIRST;
                    end
                end
            end
            PH_TOPLEN: begin
                count_down = 1'b1;
                if (lbc_reg == 3'd0) begin
                    tlen_next = {in_byte, 8'd0};
                    lbc_next  = 3'd1;
                end else begin
                    tlen_next  = tlen_reg | {8'd0, in_byte};
                    lbc_next   = 3'd2;
                    tleft_next = tlen_next;
                    phase_next = (tlen_next != '0) ? PH_TOPIC : after_topic;
                    hdone      = (phase_next == PH_BODY);
                end
            end
            PH_TOPIC: begin
                count_down = 1'b1;
                tleft_next = tleft_reg - 16'd1;
                if (tleft_next == '0) begin
                    phase_next = after_topic;
                    hdone      = (phase_next == PH_BODY);
                end
            end
            PH_ID: begin
                count_down = 1'b1;
                id_next    = {id_reg[7:0], in_byte};
                idc_next   = idc_reg + 2'd1;
                if (idc_next >= 2'd2) begin
                    phase_next = PH_BODY;
                    hdone      = 1'b1;
                end
            end
            PH_BODY: begin
                count_down = 1'b1;
            end
            default: begin
                // First byte of a packet: type, QoS and a fresh header.
                type_next  = in_byte[7:4];
                qos_next   = in_byte[2:1];
                acc_next   = '0;
                lbc_next   = 3'd0;
                left_next  = '0;
                tlen_next  = '0;
                tleft_next = '0;
                id_next    = '0;
                idc_next   = 2'd0;
                phase_next = PH_LEN;
            end
        endcase

        // Every byte after the length counts down the remaining length.
        if (count_down) begin
            if (left_reg != '0) begin
                left_next = left_reg - 28'd1;
            end
            if (left_next == '0) begin
                pend       = 1'b1;
                err        = (phase_next != PH_BODY);
                phase_next = PH_FIRST;
            end
        end
    end

    // Publish payload size once the topic length is known.
    always_comb begin
        tl_known = (type_next == mrhp_pkg::TYPE_PUBLISH) &&
                   ((phase_reg == PH_TOPLEN && lbc_next == 3'd2) ||
                    phase_reg == PH_TOPIC || phase_reg == PH_ID ||
                    phase_reg == PH_BODY);
        need     = 18'd2 + 18'(tlen_next) + ((qos_next != '0) ? 18'd2 : 18'd0);
        payload  = '0;
        if (tl_known && (28'(need) <= acc_next)) begin
            payload = acc_next - 28'(need);
        end
    end

    // Result item for this byte.
    always_comb begin
        res.byte_out         = in_byte;
        res.section          = phase_reg;
        res.packet_type      = type_next;
        res.qos              = qos_next;
        res.remaining_length = acc_next;
        res.topic_size       = tlen_next;
        res.packet_id        = (idc_next >= 2'd2) ? id_next : '0;
        res.payload_length   = payload;
        res.header_done      = hdone;
        res.packet_end       = pend;
        res.error            = err;
    end

    // Header state, updated once per consumed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            type_reg  <= '0;
            qos_reg   <= '0;
            acc_reg   <= '0;
            lbc_reg   <= '0;
            left_reg  <= '0;
            tlen_reg  <= '0;
            tleft_reg <= '0;
            id_reg    <= '0;
            idc_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            qos_reg   <= qos_next;
            acc_reg   <= acc_next;
            lbc_reg   <= lbc_next;
            left_reg  <= left_next;
            tlen_reg  <= tlen_next;
            tleft_reg <= tleft_next;
            id_reg    <= id_next;
            idc_reg   <= idc_next;
        end
    end

endmodule

// File: rtl/mrhp_out_reg.sv
// Result register: holds one result item until the consumer takes it.
module mrhp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  mrhp_pkg::result_t res,
    input  logic              m_ready,
    output logic              m_valid,
    output mrhp_pkg::result_t out_res
);

    logic              valid_reg;
    mrhp_pkg::result_t res_reg;

    assign m_valid = valid_reg;
    assign out_res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload loads with each new item and needs no reset.
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

endmodule

// File: rtl/mqtt_response_header_parser_top.sv
// A result is registered when its byte leaves the input register; the byte waits
// there until the result register is empty or being emptied.
// Throughput: one byte per cycle while the consumer takes results without stalling.
// Reset: synchronous, active low; both registers empty and the parser expecting the
// first byte of a packet with all header fields cleared.
module mqtt_response_header_parser_top #(
    parameter int unsigned MAX_LENGTH_BYTES = mrhp_pkg::MAX_LENGTH_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mrhp_pkg::BYTE_W-1:0]     s_data_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mrhp_pkg::BYTE_W-1:0]     m_byte_out,
    output logic [mrhp_pkg::SEC_W-1:0]      m_section,
    output logic [mrhp_pkg::TYPE_W-1:0]     m_packet_type,
    output logic [mrhp_pkg::QOS_W-1:0]      m_qos,
    output logic [mrhp_pkg::LEN_W-1:0]      m_remaining_length,
    output logic [mrhp_pkg::TOPIC_W-1:0]    m_topic_length,
    output logic [mrhp_pkg::ID_W-1:0]       m_packet_id,
    output logic [mrhp_pkg::LEN_W-1:0]      m_payload_length,
    output logic                            m_header_done,
    output logic                            m_packet_end,
    output logic                            m_error
);

    logic                        in_valid;
    logic [mrhp_pkg::BYTE_W-1:0] in_byte;
    logic                        advance;
    mrhp_pkg::result_t           res;
    mrhp_pkg::result_t           out_res;

    // A byte moves on when the result register is empty or being emptied.
    assign advance = in_valid && (!m_valid || m_ready);

    mrhp_in_reg u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .advance     (advance),
        .in_valid    (in_valid),
        .in_byte     (in_byte)
    );

    mrhp_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_byte (in_byte),
        .res     (res)
    );

    mrhp_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .res     (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .out_res (out_res)
    );

    assign m_byte_out         = out_res.byte_out;
    assign m_section          = out_res.section;
    assign m_packet_type      = out_res.packet_type;
    assign m_qos              = out_res.qos;
    assign m_remaining_length = out_res.remaining_length;
    assign m_topic_length     = out_res.topic_size;
    assign m_packet_id        = out_res.packet_id;
    assign m_payload_length   = out_res.payload_length;
    assign m_header_done      = out_res.header_done;
    assign m_packet_end       = out_res.packet_end;
    assign m_error            = out_res.error;

endmodule

// File: rtl/mrhp_checker.sv
// Port-level checks on the parser's result stream.
module mrhp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [mrhp_pkg::BYTE_W-1:0]     m_byte_out,
    input logic [mrhp_pkg::SEC_W-1:0]      m_section,
    input logic [mrhp_pkg::TYPE_W-1:0]     m_packet_type,
    input logic                            m_header_done,
    input logic                            m_packet_end,
    input logic                            m_error
);

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    // A stalled result keeps its byte.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_out) && $stable(m_section))
        else $error("stalled result changed");

    // Every error closes the packet.
    a_error_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_packet_end)
        else $error("error without packet end");

    // The first byte of a packet never finishes the header or the packet.
    a_first_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_section == mrhp_pkg::SEC_FIRST |-> !m_packet_end && !m_header_done)
        else $error("first byte flagged as header or packet end");

    // Topic bytes only occur inside a PUBLISH packet.
    a_topic_publish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_section == mrhp_pkg::SEC_TOPIC |->
            m_packet_type == mrhp_pkg::TYPE_PUBLISH)
        else $error("topic byte outside a publish packet");

endmodule

bind mqtt_response_header_parser_top mrhp_checker u_mrhp_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_byte_out         (m_byte_out),
    .m_section          (m_section),
    .m_packet_type      (m_packet_type),
    .m_header_done      (m_header_done),
    .m_packet_end       (m_packet_end),
    .m_error            (m_error)
);

// File: test/mrhp_parse_checker.sv
// Watches both channels of the MQTT response header parser, predicts the echo of
// every input byte and compares each result transfer with the oldest prediction.
module mrhp_parse_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [mrhp_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [mrhp_pkg::BYTE_W-1:0]   m_byte_out,
    input  logic [mrhp_pkg::SEC_W-1:0]    m_section,
    input  logic [mrhp_pkg::TYPE_W-1:0]   m_packet_type,
    input  logic [mrhp_pkg::QOS_W-1:0]    m_qos,
    input  logic [mrhp_pkg::LEN_W-1:0]    m_remaining_length,
    input  logic [mrhp_pkg::TOPIC_W-1:0]  m_topic_length,
    input  logic [mrhp_pkg::ID_W-1:0]     m_packet_id,
    input  logic [mrhp_pkg::LEN_W-1:0]    m_payload_length,
    input  logic                          m_header_done,
    input  logic                          m_packet_end,
    input  logic                          m_error,
    output int                            fail_count,
    output int                            results_owed
);

    // Shadow copy of the parser's header state.
    logic [mrhp_pkg::SEC_W-1:0]   cur_sec;
    logic [mrhp_pkg::TYPE_W-1:0]  hdr_type;
    logic [mrhp_pkg::QOS_W-1:0]   hdr_qos;
    logic [mrhp_pkg::LEN_W-1:0]   len_acc;
    logic [2:0]                   len_cnt;
    logic [mrhp_pkg::LEN_W-1:0]   left_in_pkt;
    logic [mrhp_pkg::TOPIC_W-1:0] topic_len;
    logic [mrhp_pkg::TOPIC_W-1:0] topic_left;
    logic [mrhp_pkg::ID_W-1:0]    id_acc;
    logic [1:0]                   id_cnt;

    // Echoes predicted for accepted bytes, oldest first.
    mrhp_pkg::result_t predicted_echoes[$];

    // Advances the shadow state by one byte and returns the echo it should produce.
    function automatic mrhp_pkg::result_t decode_byte(input logic [mrhp_pkg::BYTE_W-1:0] b);
        mrhp_pkg::result_t          r;
        logic [mrhp_pkg::SEC_W-1:0] sec;
        logic [mrhp_pkg::SEC_W-1:0] nxt;
        logic [mrhp_pkg::LEN_W-1:0] digit;
        logic                       count_down;
        int unsigned                need;
        r = '0;
        count_down = 1'b0;
        sec = (cur_sec > mrhp_pkg::SEC_BODY) ? mrhp_pkg::SEC_FIRST : cur_sec;
        nxt = sec;
        case (sec)
            mrhp_pkg::SEC_FIRST: begin
                hdr_type    = b[7:4];
                hdr_qos     = b[2:1];
                len_acc     = '0;
                len_cnt     = '0;
                left_in_pkt = '0;
                topic_len   = '0;
                topic_left  = '0;
                id_acc      = '0;
                id_cnt      = '0;
                nxt         = mrhp_pkg::SEC_LEN;
            end
            mrhp_pkg::SEC_LEN: begin
                if (len_cnt < 3'd4) begin
                    digit   = {{(mrhp_pkg::LEN_W-7){1'b0}}, b[6:0]};
                    len_acc = len_acc + (digit << (7 * len_cnt));
                end
                len_cnt = len_cnt + 3'd1;
                if (b[7]) begin
                    // A continuation bit on the last allowed length byte is an overrun.
                    if (len_cnt >= mrhp_pkg::MAX_LENGTH_BYTES) begin
                        r.error      = 1'b1;
                        r.packet_end = 1'b1;
                        nxt          = mrhp_pkg::SEC_FIRST;
                    end
                end else begin
                    left_in_pkt = len_acc;
                    if (hdr_type == mrhp_pkg::TYPE_PUBLISH) begin
                        nxt     = mrhp_pkg::SEC_TOPLEN;
                        len_cnt = '0;
                    end else if (hdr_type == mrhp_pkg::TYPE_PUBACK ||
                                 hdr_type == mrhp_pkg::TYPE_SUBACK) begin
                        nxt = mrhp_pkg::SEC_ID;
                    end else begin
                        nxt = mrhp_pkg::SEC_BODY;
                        r.header_done = 1'b1;
                    end
                    // A zero length ends the packet here; an error if fields were owed.
                    if (left_in_pkt == '0) begin
                        r.packet_end = 1'b1;
                        r.error      = (nxt != mrhp_pkg::SEC_BODY);
                        nxt          = mrhp_pkg::SEC_FIRST;
                    end
                end
            end
            mrhp_pkg::SEC_TOPLEN: begin
                count_down = 1'b1;
                if (len_cnt == 3'd0) begin
                    topic_len = {b, 8'h00};
                    len_cnt   = 3'd1;
                end else begin
                    topic_len  = topic_len | {8'h00, b};
                    len_cnt    = 3'd2;
                    topic_left = topic_len;
                    if (topic_left != '0) begin
                        nxt = mrhp_pkg::SEC_TOPIC;
                    end else begin
                        nxt = (hdr_qos != '0) ? mrhp_pkg::SEC_ID : mrhp_pkg::SEC_BODY;
                    end
                    r.header_done = (nxt == mrhp_pkg::SEC_BODY);
                end
            end
            mrhp_pkg::SEC_TOPIC: begin
                count_down = 1'b1;
                topic_left = topic_left - 16'd1;
                if (topic_left == '0) begin
                    nxt = (hdr_qos != '0) ? mrhp_pkg::SEC_ID : mrhp_pkg::SEC_BODY;
                    r.header_done = (nxt == mrhp_pkg::SEC_BODY);
                end
            end
            mrhp_pkg::SEC_ID: begin
                count_down = 1'b1;
                id_acc = {id_acc[7:0], b};
                id_cnt = id_cnt + 2'd1;
                if (id_cnt >= 2'd2) begin
                    nxt = mrhp_pkg::SEC_BODY;
                    r.header_done = 1'b1;
                end
            end
            default: begin
                count_down = 1'b1;
            end
        endcase

        // Every byte after the length uses up one byte of the remaining length.
        if (count_down) begin
            if (left_in_pkt != '0) begin
                left_in_pkt = left_in_pkt - 28'd1;
            end
            if (left_in_pkt == '0) begin
                r.packet_end = 1'b1;
                r.error      = (nxt != mrhp_pkg::SEC_BODY);
                nxt          = mrhp_pkg::SEC_FIRST;
            end
        end

        // The payload size is known once the whole topic length has been seen.
        if (hdr_type == mrhp_pkg::TYPE_PUBLISH &&
            ((sec == mrhp_pkg::SEC_TOPLEN && len_cnt == 3'd2) ||
             sec == mrhp_pkg::SEC_TOPIC || sec == mrhp_pkg::SEC_ID ||
             sec == mrhp_pkg::SEC_BODY)) begin
            need = 2 + topic_len + ((hdr_qos != '0) ? 2 : 0);
            if (need <= len_acc) begin
                r.payload_length = len_acc - need[mrhp_pkg::LEN_W-1:0];
            end
        end

        cur_sec            = nxt;
        r.byte_out         = b;
        r.section          = sec;
        r.packet_type      = hdr_type;
        r.qos              = hdr_qos;
        r.remaining_length = len_acc;
        r.topic_size       = topic_len;
        r.packet_id        = (id_cnt >= 2'd2) ? id_acc : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            fail_count++;
        end
    endtask

    // Results are compared before the same edge's input transfer is predicted.
    always @(posedge aclk) begin
        mrhp_pkg::result_t want;
        if (!aresetn) begin
            cur_sec     = mrhp_pkg::SEC_FIRST;
            hdr_type    = '0;
            hdr_qos     = '0;
            len_acc     = '0;
            len_cnt     = '0;
            left_in_pkt = '0;
            topic_len   = '0;
            topic_left  = '0;
            id_acc      = '0;
            id_cnt      = '0;
            predicted_echoes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_echoes.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual byte 0x%0h",
                             $time, m_byte_out);
                    fail_count++;
                end else begin
                    want = predicted_echoes.pop_front();
                    check_field("byte_out", want.byte_out, m_byte_out);
                    check_field("section", want.section, m_section);
                    check_field("packet_type", want.packet_type, m_packet_type);
                    check_field("qos", want.qos, m_qos);
                    check_field("remaining_length", want.remaining_length,
                                m_remaining_length);
                    check_field("topic size", want.topic_size, m_topic_length);
                    check_field("packet_id", want.packet_id, m_packet_id);
                    check_field("payload_length", want.payload_length, m_payload_length);
                    check_field("header_done", want.header_done, m_header_done);
                    check_field("packet_end", want.packet_end, m_packet_end);
                    check_field("error", want.error, m_error);
                end
            end
            if (s_valid && s_ready) begin
                predicted_echoes.push_back(decode_byte(s_data_byte));
            end
        end
        results_owed <= predicted_echoes.size();
    end

endmodule

// File: test/tb_mqtt_response_header_parser_top.sv
// Drives a stream of MQTT packets into the parser and gives the verdict.
module tb_mqtt_response_header_parser_top;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SLUGGISH, RX_PERIODIC} rx_mode_e;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         s_valid     = 1'b0;
    logic [mrhp_pkg::BYTE_W-1:0]  s_data_byte = '0;
    logic                         m_ready     = 1'b0;
    logic                         s_ready;
    logic                         m_valid;
    logic [mrhp_pkg::BYTE_W-1:0]  m_byte_out;
    logic [mrhp_pkg::SEC_W-1:0]   m_section;
    logic [mrhp_pkg::TYPE_W-1:0]  m_packet_type;
    logic [mrhp_pkg::QOS_W-1:0]   m_qos;
    logic [mrhp_pkg::LEN_W-1:0]   m_remaining_length;
    logic [mrhp_pkg::TOPIC_W-1:0] m_topic_length;
    logic [mrhp_pkg::ID_W-1:0]    m_packet_id;
    logic [mrhp_pkg::LEN_W-1:0]   m_payload_length;
    logic                         m_header_done;
    logic                         m_packet_end;
    logic                         m_error;
    int                           fail_count;
    int                           results_owed;

    logic [7:0]  pkt_bytes[$];
    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;
    bit          steady     = 1'b0;
    rx_mode_e    rx_mode    = RX_ALWAYS;
    int unsigned rx_timer   = 0;

    mqtt_response_header_parser_top DUT (.*);

    mrhp_parse_checker checker_inst (.*);

    always #2 aclk = ~aclk;

    // The receiver switches between stall patterns whenever its timer runs out.
    always @(posedge aclk) begin
        if (rx_timer == 0) begin
            rx_mode  <= rx_mode_e'($urandom_range(0, 3));
            rx_timer <= $urandom_range(16, 96);
        end else begin
            rx_timer <= rx_timer - 1;
        end
        case (rx_mode)
            RX_ALWAYS:   m_ready <= 1'b1;
            RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
            RX_SLUGGISH: m_ready <= ($urandom_range(0, 3) == 0);
            default:     m_ready <= (rx_timer[2:0] != 3'd0);
        endcase
    end

    // One input transfer; a new burst may open with a gap.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_packet();
        while (pkt_bytes.size() != 0) begin
            send_byte(pkt_bytes.pop_front());
        end
    endtask

    // Holds the sender off until every predicted echo has been received.
    task automatic wait_for_results();
        s_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    // Base-128 remaining length; padding stretches it to the longest encoding.
    task automatic push_length(input int unsigned len, input bit pad);
        int unsigned v;
        int unsigned n;
        logic [7:0]  lb;
        v = len;
        n = 0;
        do begin
            lb = {1'b0, v[6:0]};
            v  = v >> 7;
            if (v != 0 || (pad && n < mrhp_pkg::MAX_LENGTH_BYTES - 1)) begin
                lb[7] = 1'b1;
            end
            pkt_bytes.push_back(lb);
            n++;
        end while (v != 0 || (pad && n < mrhp_pkg::MAX_LENGTH_BYTES));
    endtask

    // Builds one packet. The bytes after the length always match the declared
    // length, so the stream stays in step even when the fields are broken.
    task automatic build_random_packet();
        int unsigned kind;
        int unsigned rem;
        int unsigned tl;
        int unsigned i;
        logic [7:0]  first;
        logic [15:0] pid;
        bit          broken;
        logic [7:0]  body[$];
        kind   = $urandom_range(0, 99);
        broken = ($urandom_range(0, 99) < 15);
        first  = 8'($urandom());
        pid    = 16'($urandom());
        if (kind < 45) begin
            // PUBLISH with topic, packet id when QoS is above 0, and payload.
            first[7:4] = mrhp_pkg::TYPE_PUBLISH;
            tl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 8);
            body.push_back(tl[15:8]);
            body.push_back(tl[7:0]);
            if (tl > 16) begin
                broken = 1'b1;
            end
            for (i = 0; i < tl && i < 16; i++) begin
                body.push_back(8'($urandom()));
            end
            if (first[2:1] != 2'd0) begin
                body.push_back(pid[15:8]);
                body.push_back(pid[7:0]);
            end
            for (i = $urandom_range(0, 12); i != 0; i--) begin
                body.push_back(8'($urandom()));
            end
        end else if (kind < 60) begin
            // Acknowledgements carrying a packet id and sometimes extra bytes.
            first[7:4] = (kind < 52) ? mrhp_pkg::TYPE_PUBACK : mrhp_pkg::TYPE_SUBACK;
            body.push_back(pid[15:8]);
            body.push_back(pid[7:0]);
            for (i = $urandom_range(0, 3); i != 0; i--) begin
                body.push_back(8'($urandom()));
            end
        end else if (kind < 90) begin
            // Any first byte with a body of random bytes.
            for (i = $urandom_range(0, 10); i != 0; i--) begin
                body.push_back(8'($urandom()));
            end
        end else begin
            // Length overrun: every allowed length byte carries a continuation bit.
            pkt_bytes.push_back(first);
            for (i = 0; i < mrhp_pkg::MAX_LENGTH_BYTES; i++) begin
                pkt_bytes.push_back(8'h80 | 8'($urandom()));
            end
            return;
        end
        rem = broken ? $urandom_range(0, body.size()) : body.size();
        pkt_bytes.push_back(first);
        push_length(rem, $urandom_range(0, 7) == 0);
        for (i = 0; i < rem; i++) begin
            pkt_bytes.push_back(body[i]);
        end
    endtask

    initial begin
        #1000000;
        $display("FAIL mqtt_response_header_parser_top");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Opening packets: zero length with no fields owed, zero-length PUBLISH,
        // largest packet id, a short SUBACK, QoS three PUBLISH, and a length overrun
        // with every length bit set.
        pkt_bytes = '{8'hD0, 8'h00,
                      8'h3B, 8'h00,
                      8'h40, 8'h02, 8'hFF, 8'hFF,
                      8'h90, 8'h01, 8'h00,
                      8'h36, 8'h06, 8'h00, 8'h01, 8'h61, 8'h12, 8'h34, 8'hFF,
                      8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet();
        wait_for_results();

        // Random packets, mostly well formed.
        while (bytes_sent < 824) begin
            steady = ($urandom_range(0, 7) == 0);
            build_random_packet();
            send_packet();
            if ($urandom_range(0, 19) == 0) begin
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS mqtt_response_header_parser_top");
        end else begin
            $display("FAIL mqtt_response_header_parser_top");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/mrhp_pkg.sv
rtl/mrhp_in_reg.sv
rtl/mrhp_parser.sv
rtl/mrhp_out_reg.sv
rtl/mqtt_response_header_parser_top.sv
rtl/mrhp_checker.sv
test/mrhp_parse_checker.sv
test/tb_mqtt_response_header_parser_top.sv
